@@ rtl/core/dependent_refcount_table_unit_assert.svh @@
// Assertion macros for the reference-count table checker.
`ifndef DEPENDENT_REFCOUNT_TABLE_UNIT_ASSERT_SVH
`define DEPENDENT_REFCOUNT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DRTU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drtu: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DRTU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drtu: next-cycle check failed");

`endif

@@ rtl/core/drtu_pkg.sv @@
package drtu_pkg;

    localparam int OP_W        = 3;
    localparam int HANDLE_W    = 6;
    localparam int RES_COUNT_W = 16;

    localparam int IN_FIELDS_W  = OP_W + HANDLE_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + HANDLE_W + RES_COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_ALLOC_DEP = 3'd1,
        OP_ACQUIRE   = 3'd2,
        OP_DOWNGRADE = 3'd3,
        OP_UPGRADE   = 3'd4,
        OP_CLEANUP   = 3'd5
    } op_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EVAL    = 7'b0000010,
        S_LINK    = 7'b0000100,
        S_DG_SLOT = 7'b0001000,
        S_DG_CNT  = 7'b0010000,
        S_DG_WR   = 7'b0100000,
        S_RESP    = 7'b1000000
    } state_t;

endpackage

@@ rtl/core/dependent_refcount_table_unit.sv @@
// Reference-count table. Items arrive on the s_axis channel (operation, handle,
// handle_present) and each one yields exactly one result item on m_axis
// (status, result_handle, result_count). Entry handles are table indexes, given
// out in order. Counts, dependent counts and dependent lists sit in three RAMs
// with one write port and one registered read port, driven by one small
// sequencer; one item is worked at a time.
// From input accept the item passes through an evaluate state and a response
// state before m_axis_tvalid; alloc dependent adds a link state, and a downgrade
// of an entry with dependents adds a slot read, a count read and a count write
// per dependent. s_axis_tready returns together with m_axis_tvalid, when the
// result is loaded into the output register.
// The result sits in an output register: when m_axis_tready is low the block
// finishes the current item, then holds it until the register drains.
// Reset empties the table at once (the fill count returns to zero, no sweep);
// the cleanup operation does the same in one item.
module dependent_refcount_table_unit
    import drtu_pkg::*;
#(
    parameter int ENTRIES        = 64,
    parameter int MAX_DEPENDENTS = 8,
    parameter int COUNT_BITS     = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation[2:0], handle[8:3], handle_present[9], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[0], result_handle[6:1], result_count[22:7], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int NF_W    = IDX_W + 1;
    localparam int CMP_W   = (NF_W > HANDLE_W) ? NF_W : HANDLE_W;
    localparam int DEPC_W  = $clog2(MAX_DEPENDENTS + 1);
    localparam int SLOTS   = ENTRIES * MAX_DEPENDENTS;
    localparam int SLOT_AW = $clog2(SLOTS);

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [IDX_W-1:0]        h_reg, h_next;
    logic                    pre_live_reg, pre_live_next;
    logic [NF_W-1:0]         next_free_reg, next_free_next;
    logic [DEPC_W-1:0]       d_reg, d_next;
    logic [DEPC_W-1:0]       d_lim_reg, d_lim_next;
    logic [IDX_W-1:0]        child_reg, child_next;
    logic                    res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]     res_handle_reg, res_handle_next;
    logic [RES_COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_status_reg, out_status_next;
    logic [HANDLE_W-1:0]     out_handle_reg, out_handle_next;
    logic [RES_COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [OP_W-1:0]         in_op;
    logic [HANDLE_W-1:0]     in_handle;
    logic                    in_present;
    logic                    in_accept;
    logic [IDX_W-1:0]        in_idx;

    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
    logic                    used_we;
    logic [IDX_W-1:0]        used_waddr, used_raddr;
    logic [DEPC_W-1:0]       used_wdata, used_rdata;
    logic                    slot_we;
    logic [SLOT_AW-1:0]      slot_waddr, slot_raddr;
    logic [IDX_W-1:0]        slot_wdata, slot_rdata;

    logic [IDX_W-1:0]        new_idx;
    logic                    table_full;
    logic                    live;
    logic [COUNT_BITS-1:0]   cnt_dec;
    logic [SLOT_AW-1:0]      slot_base;

    assign in_op      = s_axis_tdata[OP_W-1:0];
    assign in_handle  = s_axis_tdata[OP_W+HANDLE_W-1:OP_W];
    assign in_present = s_axis_tdata[OP_W+HANDLE_W];
    assign in_idx     = IDX_W'(in_handle);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_count_reg, out_handle_reg, out_status_reg});

    assign new_idx    = next_free_reg[IDX_W-1:0];
    assign table_full = (next_free_reg >= NF_W'(ENTRIES));
    assign live       = pre_live_reg && (cnt_rdata != '0);
    assign cnt_dec    = cnt_rdata - COUNT_BITS'(1);
    assign slot_base  = SLOT_AW'(h_reg) * SLOT_AW'(MAX_DEPENDENTS);

    drtu_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    drtu_ram #(
        .WIDTH(DEPC_W),
        .DEPTH(ENTRIES)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    drtu_ram #(
        .WIDTH(IDX_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        h_next          = h_reg;
        pre_live_next   = pre_live_reg;
        next_free_next  = next_free_reg;
        d_next          = d_reg;
        d_lim_next      = d_lim_reg;
        child_next      = child_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_count_next  = out_count_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = h_reg;
        cnt_wdata  = cnt_rdata;
        cnt_raddr  = h_reg;
        used_we    = 1'b0;
        used_waddr = h_reg;
        used_wdata = '0;
        used_raddr = h_reg;
        slot_we    = 1'b0;
        slot_waddr = slot_base + SLOT_AW'(used_rdata);
        slot_wdata = new_idx;
        slot_raddr = slot_base + SLOT_AW'(d_reg);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_raddr  = in_idx;
                used_raddr = in_idx;
                if (in_accept)
                begin
                    op_next       = in_op;
                    h_next        = in_idx;
                    pre_live_next = in_present
                                    && (CMP_W'(in_handle) < CMP_W'(next_free_reg));
                    state_next    = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_status_next = STATUS_FAIL;
                res_handle_next = '0;
                res_count_next  = '0;
                state_next      = S_RESP;
                case (op_reg) inside
                    OP_ALLOC:
                    begin
                        if (!table_full)
                        begin
                            cnt_we          = 1'b1;
                            cnt_waddr       = new_idx;
                            cnt_wdata       = COUNT_BITS'(1);
                            used_we         = 1'b1;
                            used_waddr      = new_idx;
                            used_wdata      = '0;
                            next_free_next  = next_free_reg + NF_W'(1);
                            res_status_next = STATUS_OK;
                            res_handle_next = HANDLE_W'(new_idx);
                            res_count_next  = RES_COUNT_W'(1);
                        end
                    end

                    OP_ALLOC_DEP:
                    begin
                        if (!table_full && live
                            && (used_rdata < DEPC_W'(MAX_DEPENDENTS)))
                        begin
                            cnt_we          = 1'b1;
                            cnt_waddr       = new_idx;
                            cnt_wdata       = cnt_rdata;
                            used_we         = 1'b1;
                            used_waddr      = h_reg;
                            used_wdata      = used_rdata + DEPC_W'(1);
                            slot_we         = 1'b1;
                            child_next      = new_idx;
                            next_free_next  = next_free_reg + NF_W'(1);
                            res_status_next = STATUS_OK;
                            res_handle_next = HANDLE_W'(new_idx);
                            res_count_next  = RES_COUNT_W'(cnt_rdata);
                            state_next      = S_LINK;
                        end
                    end

                    OP_ACQUIRE, OP_UPGRADE:
                    begin
                        if (live)
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = (cnt_rdata == '1) ? cnt_rdata
                                                          : cnt_rdata + COUNT_BITS'(1);
                            res_status_next = STATUS_OK;
                            res_handle_next = HANDLE_W'(h_reg);
                            res_count_next  = RES_COUNT_W'(cnt_wdata);
                        end
                    end

                    OP_DOWNGRADE:
                    begin
                        if (live)
                        begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cnt_dec;
                            d_next     = '0;
                            d_lim_next = used_rdata;
                            if (cnt_dec != '0)
                            begin
                                res_status_next = STATUS_OK;
                                res_handle_next = HANDLE_W'(h_reg);
                                res_count_next  = RES_COUNT_W'(cnt_dec);
                            end
                            if (used_rdata != '0)
                            begin
                                state_next = S_DG_SLOT;
                            end
                        end
                    end

                    OP_CLEANUP:
                    begin
                        next_free_next  = '0;
                        res_status_next = STATUS_OK;
                    end

                    default:
                    begin
                        res_status_next = STATUS_FAIL;
                    end
                endcase
            end

            S_LINK:
            begin
                used_we    = 1'b1;
                used_waddr = child_reg;
                used_wdata = '0;
                state_next = S_RESP;
            end

            S_DG_SLOT:
            begin
                state_next = S_DG_CNT;
            end

            S_DG_CNT:
            begin
                cnt_raddr  = slot_rdata;
                child_next = slot_rdata;
                state_next = S_DG_WR;
            end

            S_DG_WR:
            begin
                cnt_waddr = child_reg;
                cnt_wdata = cnt_dec;
                cnt_we    = (NF_W'(child_reg) < NF_W'(ENTRIES)) && (cnt_rdata != '0);
                d_next    = d_reg + DEPC_W'(1);
                if (d_next == d_lim_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_DG_SLOT;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        h_reg          <= h_next;
        pre_live_reg   <= pre_live_next;
        d_reg          <= d_next;
        d_lim_reg      <= d_lim_next;
        child_reg      <= child_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_count_reg  <= out_count_next;
    end

endmodule

@@ rtl/core/drtu_ram.sv @@
module drtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/drtu_checker.sv @@
`include "dependent_refcount_table_unit_assert.svh"

module drtu_checker
    import drtu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_accept;
    logic out_fail;
    logic in_cleanup;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_fail   = m_axis_tvalid && (m_axis_tdata[0] == STATUS_FAIL);
    assign in_cleanup = in_accept && (s_axis_tdata[OP_W-1:0] == OP_CLEANUP);

    `DRTU_ASSERT_NXT(a_busy_after_accept, in_accept, !s_axis_tready)
    `DRTU_ASSERT_IMP(a_fail_zero_payload, out_fail, m_axis_tdata[OUT_TDATA_W-1:1] == '0)
    `DRTU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    `DRTU_ASSERT_NXT(a_cleanup_busy, in_cleanup, !s_axis_tready && !$rose(m_axis_tvalid))

endmodule

bind dependent_refcount_table_unit drtu_checker u_drtu_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import drtu_pkg::*;

    localparam int ENTRIES        = 64;
    localparam int MAX_DEPENDENTS = 8;
    localparam int COUNT_BITS     = 16;
    localparam int DEP_IDX_W      = $clog2(MAX_DEPENDENTS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OP_W-1:0] OP_BAD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_7 = 3'd7;
    localparam int SAT_RAMP_ITEMS = 40;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int TAIL_CYCLES    = 40;
    localparam int CYCLE_LIMIT    = 20000000;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic                   status;
        logic [HANDLE_W-1:0]    hnd;
        logic [RES_COUNT_W-1:0] count;
    } resp_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [HANDLE_W-1:0]    hnd;
        logic                   pres;
        logic                   typed;
        logic                   status;
        logic [HANDLE_W-1:0]    res_hnd;
        logic [RES_COUNT_W-1:0] res_count;
    } dir_row_t;

    localparam int DIR_N = 21;

    dir_row_t dir_tab [DIR_N] = '{
        '{OP_ACQUIRE,   6'd0,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ALLOC,     6'd63, 1'b1, 1'b1, STATUS_OK,   6'd0, 16'd1},
        '{OP_ALLOC,     6'd0,  1'b0, 1'b1, STATUS_OK,   6'd1, 16'd1},
        '{OP_ACQUIRE,   6'd0,  1'b0, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ACQUIRE,   6'd2,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ACQUIRE,   6'd0,  1'b1, 1'b0, STATUS_OK,   6'd0, 16'd0},
        '{OP_UPGRADE,   6'd1,  1'b1, 1'b0, STATUS_OK,   6'd0, 16'd0},
        '{OP_ALLOC_DEP, 6'd0,  1'b1, 1'b0, STATUS_OK,   6'd0, 16'd0},
        '{OP_ALLOC_DEP, 6'd0,  1'b0, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ALLOC_DEP, 6'd63, 1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_BAD_6,     6'd0,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_BAD_7,     6'd63, 1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_DOWNGRADE, 6'd0,  1'b1, 1'b0, STATUS_OK,   6'd0, 16'd0},
        '{OP_DOWNGRADE, 6'd0,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ACQUIRE,   6'd0,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ALLOC_DEP, 6'd0,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_DOWNGRADE, 6'd2,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_UPGRADE,   6'd1,  1'b1, 1'b0, STATUS_OK,   6'd0, 16'd0},
        '{OP_CLEANUP,   6'd63, 1'b1, 1'b1, STATUS_OK,   6'd0, 16'd0},
        '{OP_ACQUIRE,   6'd1,  1'b1, 1'b1, STATUS_FAIL, 6'd0, 16'd0},
        '{OP_ALLOC,     6'd5,  1'b0, 1'b1, STATUS_OK,   6'd0, 16'd1}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // operation[2:0], handle[8:3], handle_present[9], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status[0], result_handle[6:1], result_count[22:7], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [COUNT_BITS-1:0]  cnt_mem  [ENTRIES];
    logic [HANDLE_W-1:0]    dep_slot [ENTRIES][MAX_DEPENDENTS];
    logic [3:0]             dep_used [ENTRIES];
    logic [6:0]             fill_idx;

    resp_t result_q [$];
    resp_t seen;
    resp_t want;
    int    mismatch_cnt = 0;
    int    fail_cnt = 0;
    int    burst_left = 0;
    bit    idle_en = 1'b1;
    int    cyc = 0;
    int    rx_tick = 0;
    int    rx_mode = 0;
    int    rx_run = 0;
    logic  rx_level = 1'b1;

    dependent_refcount_table_unit #(
        .ENTRIES        (ENTRIES),
        .MAX_DEPENDENTS (MAX_DEPENDENTS),
        .COUNT_BITS     (COUNT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic void table_clear();
        for (int e = 0; e < ENTRIES; e++)
        begin
            cnt_mem[e]  = '0;
            dep_used[e] = '0;
        end
        fill_idx = '0;
    endfunction

    function automatic resp_t refcount_step(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                            logic pres);
        resp_t                 r;
        logic                  live;
        logic [HANDLE_W-1:0]   k;
        logic [HANDLE_W-1:0]   c;
        bit                    room;
        r.status = STATUS_FAIL;
        r.hnd    = '0;
        r.count  = '0;
        live = pres && ({1'b0, h} < fill_idx) && (cnt_mem[h] != '0);
        room = (fill_idx < ENTRIES);
        k    = fill_idx[HANDLE_W-1:0];
        case (op)
            OP_ALLOC:
            begin
                if (room)
                begin
                    cnt_mem[k]  = COUNT_BITS'(1);
                    dep_used[k] = '0;
                    fill_idx    = fill_idx + 7'd1;
                    r.status    = STATUS_OK;
                    r.hnd       = k;
                    r.count     = 16'd1;
                end
            end
            OP_ALLOC_DEP:
            begin
                if (room && live && dep_used[h] < MAX_DEPENDENTS)
                begin
                    cnt_mem[k]  = cnt_mem[h];
                    dep_used[k] = '0;
                    dep_slot[h][dep_used[h][DEP_IDX_W-1:0]] = k;
                    dep_used[h] = dep_used[h] + 4'd1;
                    fill_idx    = fill_idx + 7'd1;
                    r.status    = STATUS_OK;
                    r.hnd       = k;
                    r.count     = cnt_mem[k];
                end
            end
            OP_ACQUIRE, OP_UPGRADE:
            begin
                if (live)
                begin
                    if (cnt_mem[h] != COUNT_MAX)
                        cnt_mem[h] = cnt_mem[h] + COUNT_BITS'(1);
                    r.status = STATUS_OK;
                    r.hnd    = h;
                    r.count  = cnt_mem[h];
                end
            end
            OP_DOWNGRADE:
            begin
                if (live)
                begin
                    cnt_mem[h] = cnt_mem[h] - COUNT_BITS'(1);
                    for (int d = 0; d < dep_used[h]; d++)
                    begin
                        c = dep_slot[h][d];
                        if (cnt_mem[c] != '0)
                            cnt_mem[c] = cnt_mem[c] - COUNT_BITS'(1);
                    end
                    if (cnt_mem[h] != '0)
                    begin
                        r.status = STATUS_OK;
                        r.hnd    = h;
                        r.count  = cnt_mem[h];
                    end
                end
            end
            OP_CLEANUP:
            begin
                table_clear();
                r.status = STATUS_OK;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                             input logic pres, input logic typed, input resp_t typed_res);
        resp_t pred;
        int    gap;
        if (idle_en && burst_left == 0)
        begin
            gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 20);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({pres, h, op});
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        pred = refcount_step(op, h, pres);
        result_q.push_back(typed ? typed_res : pred);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int                  r;
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] h;
        logic                pres;
        r = $urandom_range(0, 99);
        if (r < 18)
            op = OP_ALLOC;
        else if (r < 38)
            op = OP_ALLOC_DEP;
        else if (r < 52)
            op = OP_ACQUIRE;
        else if (r < 62)
            op = OP_UPGRADE;
        else if (r < 88)
            op = OP_DOWNGRADE;
        else if (r < 91)
            op = OP_CLEANUP;
        else if (r < 94)
            op = ($urandom_range(0, 1) != 0) ? OP_BAD_7 : OP_BAD_6;
        else
            op = OP_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0 || fill_idx == 0)
            h = HANDLE_W'($urandom_range(0, ENTRIES - 1));
        else
            h = HANDLE_W'($urandom_range(0, int'(fill_idx) - 1));
        pres = ($urandom_range(0, 15) != 0);
        send_item(op, h, pres, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.status = m_axis_tdata[0];
            seen.hnd    = m_axis_tdata[6:1];
            seen.count  = m_axis_tdata[22:7];
            if (result_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected item: status %0d handle %0d count %0d",
                             seen.status, seen.hnd, seen.count);
            end
            else
            begin
                want = result_q.pop_front();
                if (seen.status !== want.status || seen.hnd !== want.hnd
                    || seen.count !== want.count)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("mismatch: exp status %0d handle %0d count %0d, got %0d %0d %0d",
                                 want.status, want.hnd, want.count,
                                 seen.status, seen.hnd, seen.count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_tick % 256 == 0)
            rx_mode = $urandom_range(0, 5);
        case (rx_mode)
            0, 1: m_axis_tready <= 1'b1;
            2: m_axis_tready <= ($urandom_range(0, 1) != 0);
            3: m_axis_tready <= (rx_tick % 4 == 0);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_level = ~rx_level;
                    rx_run   = $urandom_range(1, 12);
                end
                rx_run--;
                m_axis_tready <= rx_level;
            end
        endcase
        rx_tick++;
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        table_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_item(dir_tab[i].op, dir_tab[i].hnd, dir_tab[i].pres, dir_tab[i].typed,
                      {dir_tab[i].status, dir_tab[i].res_hnd, dir_tab[i].res_count});

        // fill the dependent list of entry 0 past its end, then walk it
        for (int i = 0; i <= MAX_DEPENDENTS; i++)
            send_item(OP_ALLOC_DEP, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_ACQUIRE, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_DOWNGRADE, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_DOWNGRADE, 6'd0, 1'b1, 1'b0, '0);
        wait_drained();

        // fill the table, then push against the full table
        while (fill_idx < ENTRIES)
            send_item(OP_ALLOC, HANDLE_W'($urandom_range(0, ENTRIES - 1)), 1'b1, 1'b0, '0);
        send_item(OP_ALLOC, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_ALLOC_DEP, 6'd63, 1'b1, 1'b0, '0);
        send_item(OP_ACQUIRE, 6'd63, 1'b1, 1'b0, '0);
        send_item(OP_CLEANUP, 6'd0, 1'b0, 1'b0, '0);
        wait_drained();

        // ramp one count with no sender gaps
        idle_en = 1'b0;
        send_item(OP_ALLOC, 6'd0, 1'b0, 1'b0, '0);
        for (int i = 0; i < SAT_RAMP_ITEMS; i++)
            send_item((i % 2 != 0) ? OP_UPGRADE : OP_ACQUIRE, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_ALLOC_DEP, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_UPGRADE, 6'd1, 1'b1, 1'b0, '0);
        send_item(OP_DOWNGRADE, 6'd0, 1'b1, 1'b0, '0);
        send_item(OP_ACQUIRE, 6'd1, 1'b1, 1'b0, '0);
        send_item(OP_CLEANUP, 6'd0, 1'b1, 1'b0, '0);
        idle_en = 1'b1;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 300 == 150)
                idle_en = ~idle_en;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_random();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (result_q.size() != 0)
            fail_cnt++;
        if (mismatch_cnt == 0 && fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
